/* rtl/wvsd_pkg.sv */
// Shared types, constants and the arctangent table for the wind speed and direction block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package wvsd_pkg;

  // Field widths of the channels.
  localparam int IN_W  = 16;
  localparam int OUT_W = 9;
  localparam int CFG_W = 16;

  // Internal datapath widths.
  localparam int XY_W = 35;   // CORDIC x and y, input scaled by 2^16 plus growth
  localparam int Z_W  = 27;   // CORDIC angle in units of 2^-16 degree
  localparam int R_W  = 60;   // speed search remainder
  localparam int D_W  = 48;   // speed search step term
  localparam int K_W  = 9;    // speed in knots
  localparam int L_W  = 56;   // squared magnitude times 5^10

  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DEG_SHIFT        = 16;

  // Half a turn in units of 2^-16 degree.
  localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 * 65536);

  // Speed search: k knots is reached when (2k-1)^2 * 16 * 51479^2 <= s * 5^10.
  localparam logic [L_W-1:0]        SPEED_MUL = L_W'(9765625);
  localparam logic signed [R_W-1:0] KNOT_C    = R_W'(64'sd42401399056);
  localparam logic signed [D_W-1:0] D_INIT    = -D_W'(64'sd42401399056);

  // Direction arithmetic, in units of 1/3276800 degree. The bias holds the
  // 180 degree turn, half a unit for rounding and an offset of 400 whole
  // degrees that keeps the sum positive before the division.
  localparam logic signed [33:0] ROT_BIAS  = 34'sd1902182400;
  localparam int                 ROT_SHIFT = 17;
  localparam logic [15:0]        RECIP     = 16'd41944;   // ceil(2^20 / 25)
  localparam int                 RECIP_SH  = 20;
  localparam int                 Q_OFFSET  = 400;
  localparam int                 DIR_TURN  = 360;
  localparam int                 LON_HALF  = 18000;
  localparam int                 LON_TURN  = 36000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CONE     = 2'd0,
    REG_GRID_REF = 2'd1,
    REG_STATION  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] cone;
    logic signed [CFG_W-1:0] grid_ref;
    logic signed [CFG_W-1:0] station;
  } cfg_t;

  // Everything one request carries down the row of cells.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    logic signed [R_W-1:0]  r;
    logic signed [D_W-1:0]  d;
    logic [K_W-1:0]         k;
  } lane_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = Z_W'(2949120);
      1:       a = Z_W'(1740967);
      2:       a = Z_W'(919879);
      3:       a = Z_W'(466945);
      4:       a = Z_W'(234379);
      5:       a = Z_W'(117304);
      6:       a = Z_W'(58666);
      7:       a = Z_W'(29335);
      8:       a = Z_W'(14668);
      9:       a = Z_W'(7334);
      10:      a = Z_W'(3667);
      11:      a = Z_W'(1833);
      12:      a = Z_W'(917);
      13:      a = Z_W'(458);
      14:      a = Z_W'(229);
      15:      a = Z_W'(115);
      16:      a = Z_W'(57);
      17:      a = Z_W'(29);
      18:      a = Z_W'(14);
      19:      a = Z_W'(7);
      20:      a = Z_W'(4);
      21:      a = Z_W'(2);
      22:      a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/wvsd_if.sv */
// Valid/ready channel interfaces: wind sample in, speed and direction out, register writes.
// Depends on wvsd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wvsd_wind_if;
  logic                            valid;
  logic                            ready;
  logic signed [wvsd_pkg::IN_W-1:0] wind_east;
  logic signed [wvsd_pkg::IN_W-1:0] wind_north;
  modport source (output valid, output wind_east, output wind_north, input ready);
  modport sink   (input valid, input wind_east, input wind_north, output ready);
endinterface

interface wvsd_result_if;
  logic                       valid;
  logic                       ready;
  logic [wvsd_pkg::OUT_W-1:0] speed_knots;
  logic [wvsd_pkg::OUT_W-1:0] direction_deg;
  modport source (output valid, output speed_knots, output direction_deg, input ready);
  modport sink   (input valid, input speed_knots, input direction_deg, output ready);
endinterface

interface wvsd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [wvsd_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/wvsd_front.sv */
// Entry stages: squares of the components, CORDIC pre-rotation, then the scaled magnitude.
// Depends on wvsd_pkg; its output feeds the first cell of the row.
`timescale 1ns / 1ps
`default_nettype none

module wvsd_front (
  input  wire logic                             clk,
  input  wire logic                             load_a,
  input  wire logic                             load_b,
  input  wire logic signed [wvsd_pkg::IN_W-1:0] east,
  input  wire logic signed [wvsd_pkg::IN_W-1:0] north,
  output wvsd_pkg::lane_t                       dout
);

  localparam int XY_W = wvsd_pkg::XY_W;
  localparam int Z_W  = wvsd_pkg::Z_W;

  logic signed [31:0]     prod_e, prod_n;
  logic signed [XY_W-1:0] xs, ys;
  logic [30:0]            sq_e, sq_n;
  logic signed [XY_W-1:0] x_a, y_a;
  logic signed [Z_W-1:0]  z_a;
  logic                   zero_a;
  logic signed [XY_W-1:0] x_a_next, y_a_next;
  logic signed [Z_W-1:0]  z_a_next;
  logic [31:0]            sum_sq;
  logic [wvsd_pkg::L_W-1:0] scaled;
  wvsd_pkg::lane_t        dout_next;

  // The vector is flipped into the right half plane when north is negative.
  always_comb begin
    prod_e = east * east;
    prod_n = north * north;
    xs = {{(XY_W-32){north[15]}}, north, 16'h0000};
    ys = {{(XY_W-32){east[15]}}, east, 16'h0000};
    x_a_next = xs;
    y_a_next = ys;
    z_a_next = '0;
    if (north[15]) begin
      x_a_next = -xs;
      y_a_next = -ys;
      z_a_next = east[15] ? -wvsd_pkg::HALF_TURN : wvsd_pkg::HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      sq_e   <= prod_e[30:0];
      sq_n   <= prod_n[30:0];
      x_a    <= x_a_next;
      y_a    <= y_a_next;
      z_a    <= z_a_next;
      zero_a <= (east == '0) && (north == '0);
    end
  end

  // The search starts at k = 0, where the odd factor 2k-1 is -1.
  always_comb begin
    sum_sq = {1'b0, sq_e} + {1'b0, sq_n};
    scaled = wvsd_pkg::L_W'(sum_sq) * wvsd_pkg::SPEED_MUL;
    dout_next.x    = x_a;
    dout_next.y    = y_a;
    dout_next.z    = z_a;
    dout_next.zero = zero_a;
    dout_next.r    = $signed({{(wvsd_pkg::R_W-wvsd_pkg::L_W){1'b0}}, scaled}) -
                     wvsd_pkg::KNOT_C;
    dout_next.d    = wvsd_pkg::D_INIT;
    dout_next.k    = '0;
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/wvsd_cell.sv */
// One cell of the row: a CORDIC vectoring micro-rotation and one bit of the speed search.
// Depends on wvsd_pkg for the lane type and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module wvsd_cell #(
  parameter int STEP      = 0,
  parameter bit CORDIC_ON = 1'b1,
  parameter bit SPEED_ON  = 1'b1
) (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire wvsd_pkg::lane_t din,
  output wvsd_pkg::lane_t      dout
);

  localparam int R_W = wvsd_pkg::R_W;
  localparam int D_W = wvsd_pkg::D_W;
  localparam int SBIT = SPEED_ON ? (wvsd_pkg::K_W - 1 - STEP) : 0;
  localparam logic signed [R_W-1:0] C_TERM = wvsd_pkg::KNOT_C <<< (2 * SBIT + 2);
  localparam logic signed [D_W-1:0] D_STEP = D_W'(wvsd_pkg::KNOT_C <<< (SBIT + 1));
  localparam logic signed [wvsd_pkg::Z_W-1:0] ATAN =
    wvsd_pkg::atan_step(CORDIC_ON ? STEP : 0);

  logic signed [wvsd_pkg::XY_W-1:0] dx, dy;
  logic signed [R_W-1:0]            d_ext, trial;
  wvsd_pkg::lane_t                  dout_next;

  always_comb begin
    dout_next = din;
    dx = din.y >>> STEP;
    dy = din.x >>> STEP;
    if (CORDIC_ON) begin
      if (!din.y[wvsd_pkg::XY_W-1]) begin
        dout_next.x = din.x + dx;
        dout_next.y = din.y - dy;
        dout_next.z = din.z + ATAN;
      end else begin
        dout_next.x = din.x - dx;
        dout_next.y = din.y + dy;
        dout_next.z = din.z - ATAN;
      end
    end
    // Raising the odd factor m by 2^(b+1) grows m^2 by m*2^(b+2) + 2^(2b+2).
    d_ext = R_W'(din.d);
    trial = din.r - (d_ext <<< (SBIT + 2)) - C_TERM;
    if (SPEED_ON && !trial[R_W-1]) begin
      dout_next.r       = trial;
      dout_next.d       = din.d + D_STEP;
      dout_next.k[SBIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/wvsd_back.sv */
// Exit stages: grid rotation, rounding and wrap of the direction, and the result register.
// Depends on wvsd_pkg; takes the last cell's lane and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module wvsd_back (
  input  wire logic                        clk,
  input  wire logic                        load_a,
  input  wire logic                        load_b,
  input  wire wvsd_pkg::cfg_t              cfg,
  input  wire wvsd_pkg::lane_t             din,
  output logic [wvsd_pkg::OUT_W-1:0]       speed,
  output logic [wvsd_pkg::OUT_W-1:0]       direction
);

  localparam logic signed [17:0] HALF18  = 18'(wvsd_pkg::LON_HALF);
  localparam logic signed [17:0] TURN18  = 18'(wvsd_pkg::LON_TURN);
  localparam logic signed [17:0] HALF3   = 18'(3 * wvsd_pkg::LON_HALF);
  localparam logic signed [17:0] TURN2   = 18'(2 * wvsd_pkg::LON_TURN);
  localparam logic signed [11:0] DTURN   = 12'(wvsd_pkg::DIR_TURN);
  localparam logic signed [11:0] QOFF    = 12'(wvsd_pkg::Q_OFFSET);
  localparam int                 U_W     = 15;

  logic signed [17:0] dlon_raw, dlon_next;
  logic signed [15:0] dlon;
  logic signed [31:0] rot;
  logic signed [33:0] bias;

  logic signed [wvsd_pkg::Z_W-1:0] angle;
  logic signed [33:0]              a50, t_sum;
  logic [U_W-1:0]                  u;
  logic [wvsd_pkg::K_W-1:0]        k_a;
  logic [30:0]                     q_prod;
  logic signed [11:0]              w_raw, w_next;

  // Longitude difference wrapped into plus or minus 180 degrees.
  always_comb begin
    dlon_raw = 18'(cfg.grid_ref) - 18'(cfg.station);
    if (dlon_raw > HALF3) begin
      dlon_next = dlon_raw - TURN2;
    end else if (dlon_raw > HALF18) begin
      dlon_next = dlon_raw - TURN18;
    end else if (dlon_raw < -HALF3) begin
      dlon_next = dlon_raw + TURN2;
    end else if (dlon_raw < -HALF18) begin
      dlon_next = dlon_raw + TURN18;
    end else begin
      dlon_next = dlon_raw;
    end
    rot = cfg.cone * dlon;
  end

  always_ff @(posedge clk) begin
    dlon <= dlon_next[15:0];
    bias <= wvsd_pkg::ROT_BIAS - 34'(rot);
  end

  // A zero vector has no angle; it is taken as zero.
  always_comb begin
    angle = din.zero ? '0 : din.z;
    a50   = 34'(angle) * 34'sd50;
    t_sum = a50 + bias;
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      u   <= t_sum[wvsd_pkg::ROT_SHIFT +: U_W];
      k_a <= din.k;
    end
  end

  // Division by 25 through the reciprocal, exact for every value of u.
  always_comb begin
    q_prod = 31'(u) * 31'(wvsd_pkg::RECIP);
    w_raw  = $signed({1'b0, q_prod[30:wvsd_pkg::RECIP_SH]}) - QOFF;
    if (w_raw > DTURN) begin
      w_next = w_raw - DTURN;
    end else if (w_raw < 12'sd0) begin
      w_next = w_raw + DTURN;
    end else begin
      w_next = w_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      speed     <= k_a;
      direction <= w_next[wvsd_pkg::OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/wind_vector_to_speed_direction_top.sv */
// Top level of the wind speed and direction block: channels, register file, stage control.
// Depends on wvsd_pkg, the channel interfaces, wvsd_front, wvsd_cell and wvsd_back.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one grid wind sample (eastward and northward components in
// signed Q8.8 m/s) and returns one result: the speed rounded to whole knots and the
// direction in whole degrees, rotated by the grid convergence, turned by 180 degrees
// and wrapped into 0..360. The block takes one request per clock cycle when the
// result side keeps up. Every request travels through a fixed row of stages: two entry
// stages, a row of NCELL cells, and two exit stages. NCELL is the larger of 9 and
// R = min(CORDIC_STEPS, 24). Each of the first R cells performs one CORDIC vectoring
// rotation and each of the first nine cells decides one bit of the speed, which is
// found exactly with no rounding error. Every stage holds its own valid bit and loads
// whenever it is empty or its successor moves, so a stalled result only halts the
// stages behind it once the empty stages in between have filled; the last stage is
// the result register. The direction uses R micro-rotations, so its accuracy follows
// CORDIC_STEPS. The register channel is always ready. Register writes are meant to
// happen while the block holds no request; a new value reaches the rotation term
// through the longitude difference and bias registers, well ahead of any later request.

module wind_vector_to_speed_direction_top #(
  parameter int CORDIC_STEPS = wvsd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  wvsd_wind_if.sink    wind,
  wvsd_result_if.source result,
  wvsd_cfg_if.sink     cfg
);

  // Steps beyond the arctangent table add nothing, so the row stops there.
  localparam int STEPS_EFF = (CORDIC_STEPS < wvsd_pkg::ATAN_ENTRIES) ?
                             CORDIC_STEPS : wvsd_pkg::ATAN_ENTRIES;
  localparam int NCELL     = (STEPS_EFF > wvsd_pkg::K_W) ? STEPS_EFF : wvsd_pkg::K_W;
  localparam int NSTAGE    = NCELL + 4;

  // Configuration registers, cleared by reset.
  wvsd_pkg::cfg_t cfg_regs;

  // Stage control: valid[i] marks a request held in stage i, and ready[i] says
  // that stage i may load this cycle.
  logic [NSTAGE-1:0] valid;
  logic [NSTAGE:0]   ready;

  wvsd_pkg::lane_t lane [NCELL+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (wvsd_pkg::cfg_reg_t'(cfg.index))
        wvsd_pkg::REG_CONE: begin
          cfg_regs.cone <= cfg.data;
        end
        wvsd_pkg::REG_GRID_REF: begin
          cfg_regs.grid_ref <= cfg.data;
        end
        wvsd_pkg::REG_STATION: begin
          cfg_regs.station <= cfg.data;
        end
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // A stage may load when it is empty or when its own contents move on.
  always_comb begin
    ready[NSTAGE] = result.ready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= wind.valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign wind.ready   = ready[0];
  assign result.valid = valid[NSTAGE-1];

  wvsd_front u_front (
    .clk    (clk),
    .load_a (ready[0]),
    .load_b (ready[1]),
    .east   (wind.wind_east),
    .north  (wind.wind_north),
    .dout   (lane[0])
  );

  // Cell j rotates by atan(2^-j) when j < STEPS_EFF and settles speed bit 8-j when j < 9.
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    wvsd_cell #(
      .STEP      (j),
      .CORDIC_ON (j < STEPS_EFF),
      .SPEED_ON  (j < wvsd_pkg::K_W)
    ) u_cell (
      .clk  (clk),
      .load (ready[j+2]),
      .din  (lane[j]),
      .dout (lane[j+1])
    );
  end

  wvsd_back u_back (
    .clk       (clk),
    .load_a    (ready[NSTAGE-2]),
    .load_b    (ready[NSTAGE-1]),
    .cfg       (cfg_regs),
    .din       (lane[NCELL]),
    .speed     (result.speed_knots),
    .direction (result.direction_deg)
  );

endmodule

`default_nettype wire

/* bench/wind_vector_to_speed_direction_top_test.sv */
// Self-checking testbench for wind_vector_to_speed_direction_top: speed and direction of wind samples.
// Depends on wvsd_pkg, the channel interfaces in wvsd_if.sv and the design files of the block.
`timescale 1ns / 1ps

module wind_vector_to_speed_direction_top_test;

  import wvsd_pkg::*;

  // The block is built with the default number of CORDIC rotations.
  localparam int ROT_STEPS = CORDIC_STEPS_DEF;
  // Entry and exit stages plus one cell per rotation, at least nine cells.
  localparam int LATENCY = ((ROT_STEPS < 24 ? ROT_STEPS : 24) > 9 ?
                            (ROT_STEPS < 24 ? ROT_STEPS : 24) : 9) + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int PHASES = 9;

  // Index 3 is not a register. A write there must leave every register alone.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One unit of the rotation sum is 1/3276800 degree.
  localparam longint ROT_UNIT = 64'd3276800;
  // 16 * 51479^2: the knot threshold scale of the exact speed test.
  localparam longint unsigned KNOT_SQ16 = 64'd42401399056;
  localparam longint unsigned FIVE_POW10 = 64'd9765625;

  typedef struct packed {
    logic signed [IN_W-1:0] east;
    logic signed [IN_W-1:0] north;
  } wind_sample_t;

  typedef struct packed {
    logic [OUT_W-1:0] speed;
    logic [OUT_W-1:0] heading;
  } wind_report_t;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  logic clk = 1'b0;
  logic rst;

  wvsd_wind_if   wind_ch();
  wvsd_result_if result_ch();
  wvsd_cfg_if    cfg_ch();

  wind_vector_to_speed_direction_top #(
    .CORDIC_STEPS(ROT_STEPS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .wind  (wind_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // Arctangent of 2^-i in units of 2^-16 degree, one entry per rotation.
  longint arctan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Shadow copy of the register file, updated when a write is accepted.
  logic signed [CFG_W-1:0] cone_q15;
  logic signed [CFG_W-1:0] ref_lon;
  logic signed [CFG_W-1:0] stn_lon;

  // Requests still to be offered, and reports the block still owes us.
  wind_sample_t samples_waiting[$];
  wind_report_t reports_due[$];

  logic signed [CFG_W-1:0] corner_vals [0:4] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF
  };

  int unsigned sender_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int          samples_queued = 0;
  int          samples_accepted = 0;
  int          reports_checked = 0;
  int          failures = 0;
  int          cycle_count = 0;
  wind_sample_t next_sample;
  wind_report_t owed;

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Speed in knots: the largest k for which the magnitude, rounded half up,
  // reaches k. The test (2k-1)^2 * 16 * 51479^2 <= (E^2 + N^2) * 5^10 is
  // done in integers, so there is no rounding error at all.
  function automatic logic [OUT_W-1:0] knots_of(input longint e, input longint n);
    longint unsigned energy;
    longint unsigned k;
    energy = longint'(e * e + n * n) * FIVE_POW10;
    k = 0;
    while (k < 511 && energy >= (2 * k + 1) * (2 * k + 1) * KNOT_SQ16)
      k++;
    return k[OUT_W-1:0];
  endfunction

  // atan2(east, north) by vectoring CORDIC, in units of 2^-16 degree.
  // The left half plane is folded over first with a base turn of 180 degrees,
  // whose sign follows the sign of east. A zero vector gives angle zero.
  function automatic longint heading_of(input longint e, input longint n);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int     i;
    if (e == 0 && n == 0)
      return 0;
    x = n * 65536;
    y = e * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (i = 0; i < ROT_STEPS && i < 24; i++) begin
      // Arithmetic shifts round toward minus infinity, as the hardware does.
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += arctan_q16[i];
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_q16[i];
      end
    end
    return z;
  endfunction

  // Adds the grid rotation and the 180 degree turn, rounds half up and wraps
  // once into 0..360. The longitude difference is wrapped to +-180 degrees
  // first; out-of-range register values need up to two passes.
  function automatic logic [OUT_W-1:0] bearing_of(input longint angle);
    longint span;
    longint tsum;
    longint wd;
    span = longint'(ref_lon) - longint'(stn_lon);
    while (span > 18000)
      span -= 36000;
    while (span < -18000)
      span += 36000;
    tsum = 50 * angle - longint'(cone_q15) * span + 180 * ROT_UNIT + ROT_UNIT / 2;
    wd = tsum / ROT_UNIT;
    if ((tsum % ROT_UNIT) != 0 && tsum < 0)
      wd--;
    if (wd > 360)
      wd -= 360;
    if (wd < 0)
      wd += 360;
    return wd[OUT_W-1:0];
  endfunction

  function automatic wind_report_t predict_report(input longint e, input longint n);
    wind_report_t r;
    r.speed   = knots_of(e, n);
    r.heading = bearing_of(heading_of(e, n));
    return r;
  endfunction

  // Random sample, biased toward the corners of the behavior: small vectors
  // near the rounding steps, vectors on the axes, the left half plane where
  // the CORDIC folds, and the field extremes. Half are plain full-range.
  function automatic wind_sample_t random_sample();
    wind_sample_t s;
    int unsigned  pick;
    pick = $urandom_range(0, 9);
    s.east  = 16'($urandom);
    s.north = 16'($urandom);
    case (pick)
      5: begin
        s.east  = 16'($urandom_range(0, 1023)) - 16'd512;
        s.north = 16'($urandom_range(0, 1023)) - 16'd512;
      end
      6: s.east = '0;
      7: s.north = '0;
      8: begin
        s.east  = corner_vals[$urandom_range(0, 4)];
        s.north = corner_vals[$urandom_range(0, 4)];
      end
      9: s.north = {1'b1, s.north[IN_W-2:0]};
      default: ;
    endcase
    return s;
  endfunction

  function automatic wind_sample_t make_sample(input int e, input int n);
    wind_sample_t s;
    s.east  = 16'(e);
    s.north = 16'(n);
    return s;
  endfunction

  // Sender side. A request is predicted at the edge where it is accepted;
  // the offered sample is held until then. New samples are offered whenever
  // the slot is free, except when a random gap is drawn.
  always @(posedge clk) begin
    if (rst) begin
      wind_ch.valid <= 1'b0;
    end else begin
      if (wind_ch.valid && wind_ch.ready) begin
        reports_due.push_back(predict_report(wind_ch.wind_east, wind_ch.wind_north));
        samples_accepted++;
      end
      if (!wind_ch.valid || wind_ch.ready) begin
        if (samples_waiting.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
          next_sample = samples_waiting.pop_front();
          wind_ch.valid      <= 1'b1;
          wind_ch.wind_east  <= next_sample.east;
          wind_ch.wind_north <= next_sample.north;
        end else begin
          wind_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side. Every accepted report is checked against the oldest one
  // owed; a report that nobody asked for is a failure too. Ready is redrawn
  // every cycle so stalls land on every stage of the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (reports_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("Unrequested report: speed %0d direction %0d",
                     result_ch.speed_knots, result_ch.direction_deg);
        end else begin
          owed = reports_due.pop_front();
          reports_checked++;
          if (result_ch.speed_knots !== owed.speed ||
              result_ch.direction_deg !== owed.heading) begin
            failures++;
            if (failures <= 10)
              $display("Report %0d wrong: speed %0d (want %0d) direction %0d (want %0d)",
                       reports_checked, result_ch.speed_knots, owed.speed,
                       result_ch.direction_deg, owed.heading);
          end
        end
      end
      result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog. A correct run ends far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d reports still owed",
               cycle_count, reports_due.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic set_flow(input flow_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        sender_gap_pct = 0;
        sink_stall_pct = 0;
      end
      FLOW_SENDER_GAPS: begin
        sender_gap_pct = 50;
        sink_stall_pct = 0;
      end
      FLOW_SINK_STALLS: begin
        sender_gap_pct = 0;
        sink_stall_pct = 50;
      end
      default: begin
        sender_gap_pct = 19;
        sink_stall_pct = 19;
      end
    endcase
  endtask

  task automatic queue_sample(input wind_sample_t s);
    samples_waiting.push_back(s);
    samples_queued++;
  endtask

  // Waits until every queued request has been accepted and answered, then
  // lets the pipeline run for its full depth so that it is truly empty.
  // Counting acceptances avoids racing the sender block on its queue.
  task automatic wait_drained();
    while (samples_accepted != samples_queued || reports_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // One register write on the configuration channel. The shadow copy is
  // updated at the accepting edge; the spare index changes nothing.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do
      @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_CONE:     cone_q15 = val;
      REG_GRID_REF: ref_lon  = val;
      REG_STATION:  stn_lon  = val;
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] random_lon();
    return 16'($urandom_range(0, 36000)) - 16'd18000;
  endfunction

  initial begin
    int p;
    int i;
    // Every input of the block is known from time zero.
    rst = 1'b1;
    wind_ch.valid      = 1'b0;
    wind_ch.wind_east  = '0;
    wind_ch.wind_north = '0;
    result_ch.ready    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_CONE;
    cfg_ch.data        = '0;
    cone_q15 = '0;
    ref_lon  = '0;
    stn_lon  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with the registers at their reset values. They cover
    // the zero vector, the field extremes, all four axes, the fold into the
    // left half plane with east of either sign, and the half-knot step.
    set_flow(FLOW_FREE);
    queue_sample(make_sample(0, 0));
    queue_sample(make_sample(-32768, -32768));
    queue_sample(make_sample(32767, 32767));
    queue_sample(make_sample(-32768, 32767));
    queue_sample(make_sample(32767, -32768));
    queue_sample(make_sample(-32768, 0));
    queue_sample(make_sample(0, -32768));
    queue_sample(make_sample(32767, 0));
    queue_sample(make_sample(0, 32767));
    queue_sample(make_sample(1, 0));
    queue_sample(make_sample(0, 1));
    queue_sample(make_sample(-1, 0));
    queue_sample(make_sample(0, -1));
    queue_sample(make_sample(1, -1));
    queue_sample(make_sample(-1, -1));
    queue_sample(make_sample(1, 1));
    queue_sample(make_sample(-1, 1));
    queue_sample(make_sample(65, 0));
    queue_sample(make_sample(66, 0));
    queue_sample(make_sample(0, -66));
    queue_sample(make_sample(256, 0));
    queue_sample(make_sample(-197, 132));
    wait_drained();

    // Random phases. Each phase sets the registers while the block is empty,
    // picks how the two sides idle, and streams a batch of samples. The
    // first three phases hit the register extremes, including longitudes
    // outside their stated range and a write to the unused index.
    for (p = 1; p < PHASES; p++) begin
      case (p)
        1: begin
          write_reg(REG_CONE, 16'sh7FFF);
          write_reg(REG_GRID_REF, 16'sd18000);
          write_reg(REG_STATION, -16'sd18000);
        end
        2: begin
          write_reg(REG_CONE, 16'sh8000);
          write_reg(REG_GRID_REF, -16'sd18000);
          write_reg(REG_STATION, 16'sd18000);
        end
        3: begin
          write_reg(REG_CONE, 16'($urandom));
          write_reg(REG_GRID_REF, 16'sh8000);
          write_reg(REG_STATION, 16'sh7FFF);
          write_reg(REG_SPARE, 16'($urandom));
        end
        5: begin
          write_reg(REG_CONE, 16'($urandom));
          write_reg(REG_GRID_REF, 16'($urandom));
          write_reg(REG_STATION, 16'($urandom));
        end
        default: begin
          write_reg(REG_CONE, 16'($urandom));
          write_reg(REG_GRID_REF, random_lon());
          write_reg(REG_STATION, random_lon());
        end
      endcase
      set_flow(flow_mode_t'((p - 1) % 4));
      for (i = 0; i < RANDOM_PER_PHASE; i++)
        queue_sample(random_sample());
      wait_drained();
    end

    $display("Checked %0d wind reports from %0d samples over %0d register settings,",
             reports_checked, samples_accepted, PHASES);
    $display("with free flow, sender gaps, receiver stalls and both; %0d failures.",
             failures);
    if (failures == 0 && reports_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* wind_vector_to_speed_direction_top.f */
rtl/wvsd_pkg.sv
rtl/wvsd_if.sv
rtl/wvsd_front.sv
rtl/wvsd_cell.sv
rtl/wvsd_back.sv
rtl/wind_vector_to_speed_direction_top.sv
bench/wind_vector_to_speed_direction_top_test.sv
